@@ hdl/rth_pkg.sv @@
// Shared types and constants for the RGB to HSV pixel converter.
`default_nettype none
package rth_pkg;

  // Hue is produced in 1/64 degree; one 60 degree sector is 3840 units.
  localparam int unsigned HueSector = 3840;
  localparam int unsigned HueFull   = 23040;

  // Long-division geometry: every cell retires one quotient bit of each divider.
  localparam int unsigned QuotW   = 15;
  localparam int unsigned HueDivW = 9;
  localparam int unsigned SatDivW = 8;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Result of the channel compare stage.
  typedef struct packed {
    logic [7:0]       value;
    logic [7:0]       delta;
    sector_t          sector;
    logic signed [8:0] diff;
    logic             hue_zero;
    logic             sat_zero;
    logic             undef;
  } prep_word_t;

  // Word that travels down the divider chain.
  typedef struct packed {
    logic [HueDivW-1:0] hue_div;
    logic [HueDivW-1:0] hue_rem;
    logic [QuotW-1:0]   hue_sh;
    logic [SatDivW-1:0] sat_div;
    logic [SatDivW-1:0] sat_rem;
    logic [QuotW-1:0]   sat_sh;
    logic               hue_zero;
    logic               sat_zero;
    logic               undef;
    logic [7:0]         value;
  } div_word_t;

endpackage
`default_nettype wire

@@ hdl/rth_prep.sv @@
// Channel compare stage: max, min, delta, dominant channel and special cases.
`default_nettype none
module rth_prep (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  input  wire logic [7:0]         alpha,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rth_pkg::prep_word_t     out_word
);
  import rth_pkg::*;

  prep_word_t word_next;
  logic [7:0] mx;
  logic [7:0] mn;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    // Ties go to red first, then green.
    if (red >= green && red >= blue) begin
      mx = red;
      word_next.sector = SEC_RED;
      word_next.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      mx = green;
      word_next.sector = SEC_GREEN;
      word_next.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      mx = blue;
      word_next.sector = SEC_BLUE;
      word_next.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    word_next.value    = mx;
    word_next.delta    = mx - mn;
    word_next.sat_zero = (mx == 8'd0);
    word_next.hue_zero = (mx == 8'd0) || (mx == mn);
    word_next.undef    = (mx == 8'd0) && (alpha != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rth_scale.sv @@
// Builds the hue and saturation dividends and divisors for the divider chain.
`default_nettype none
module rth_scale (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  rth_pkg::prep_word_t     in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rth_pkg::div_word_t      out_word
);
  import rth_pkg::*;

  div_word_t          word_next;
  logic signed [11:0] t_raw;
  logic [10:0]        t_pos;
  logic [23:0]        hue_num;
  logic [19:0]        sat_num;
  logic [10:0]        six_delta;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    unique case (in_word.sector)
      SEC_RED:   t_raw = 12'(in_word.diff);
      SEC_GREEN: t_raw = $signed({3'b000, in_word.delta, 1'b0}) + 12'(in_word.diff);
      SEC_BLUE:  t_raw = $signed({2'b00, in_word.delta, 2'b00}) + 12'(in_word.diff);
      default:   t_raw = 12'sd0;
    endcase
    six_delta = {1'b0, in_word.delta, 2'b00} + {2'b00, in_word.delta, 1'b0};
    // A negative hue wraps by a full turn, i.e. six sectors.
    if (t_raw < 0) begin
      t_pos = 11'(t_raw + $signed({1'b0, six_delta}));
    end else begin
      t_pos = t_raw[10:0];
    end
    // 7680 * t = (16 - 1) * t * 512, plus delta for round half up.
    hue_num = ({9'd0, t_pos, 4'd0} - {13'd0, t_pos}) * 24'd512 + {16'd0, in_word.delta};
    sat_num = {in_word.delta, 12'd0} | {13'd0, in_word.value[7:1]};

    word_next.hue_div  = {in_word.delta, 1'b0};
    word_next.hue_rem  = hue_num[23:QuotW];
    word_next.hue_sh   = hue_num[QuotW-1:0];
    word_next.sat_div  = in_word.value;
    word_next.sat_rem  = {3'd0, sat_num[19:QuotW]};
    word_next.sat_sh   = sat_num[QuotW-1:0];
    word_next.hue_zero = in_word.hue_zero;
    word_next.sat_zero = in_word.sat_zero;
    word_next.undef    = in_word.undef;
    word_next.value    = in_word.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rth_div_cell.sv @@
// One restoring division step for both the hue and the saturation quotient.
`default_nettype none
module rth_div_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  rth_pkg::div_word_t      in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rth_pkg::div_word_t      out_word
);
  import rth_pkg::*;

  div_word_t          word_next;
  logic [HueDivW:0]   hue_trial;
  logic [SatDivW:0]   sat_trial;
  logic               hue_fit;
  logic               sat_fit;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    word_next = in_word;
    // Shift the next dividend bit into the remainder; the quotient bit
    // enters at the bottom of the same shift register.
    hue_trial = {in_word.hue_rem, in_word.hue_sh[QuotW-1]};
    hue_fit   = hue_trial >= {1'b0, in_word.hue_div};
    if (hue_fit) begin
      word_next.hue_rem = HueDivW'(hue_trial - {1'b0, in_word.hue_div});
    end else begin
      word_next.hue_rem = hue_trial[HueDivW-1:0];
    end
    word_next.hue_sh = {in_word.hue_sh[QuotW-2:0], hue_fit};

    sat_trial = {in_word.sat_rem, in_word.sat_sh[QuotW-1]};
    sat_fit   = sat_trial >= {1'b0, in_word.sat_div};
    if (sat_fit) begin
      word_next.sat_rem = SatDivW'(sat_trial - {1'b0, in_word.sat_div});
    end else begin
      word_next.sat_rem = sat_trial[SatDivW-1:0];
    end
    word_next.sat_sh = {in_word.sat_sh[QuotW-2:0], sat_fit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rth_out.sv @@
// Output register: wraps a full-turn hue to zero and applies the special cases.
`default_nettype none
module rth_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  rth_pkg::div_word_t      in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [14:0]             hue,
  output logic                    hue_undefined,
  output logic [12:0]             saturation,
  output logic [7:0]              brightness
);
  import rth_pkg::*;

  logic [14:0] hue_next;
  logic [12:0] sat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    if (in_word.hue_zero) begin
      hue_next = 15'd0;
    end else if (in_word.hue_sh >= QuotW'(HueFull)) begin
      hue_next = in_word.hue_sh - QuotW'(HueFull);
    end else begin
      hue_next = in_word.hue_sh;
    end
    sat_next = in_word.sat_zero ? 13'd0 : in_word.sat_sh[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue           <= hue_next;
      hue_undefined <= in_word.undef;
      saturation    <= sat_next;
      brightness    <= in_word.value;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rgb_to_hsv_pixel.sv @@
// RGB to HSV pixel converter, top level.
// Registered stages, in order from input acceptance to output valid: compare stage,
// dividend stage, 15 division cells (one quotient bit each) and output register.
// Throughput is one pixel per clock unless the output stalls; every stage holds
// its word independently, so a stalled output only stops the stages that are full.
// Reset clears the valid flags of all stages; data registers are not reset.
`default_nettype none
module rgb_to_hsv_pixel (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [7:0]  alpha,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      hue,
  output logic             hue_undefined,
  output logic [12:0]      saturation,
  output logic [7:0]       brightness
);
  import rth_pkg::*;

  prep_word_t prep_word;
  logic       prep_valid;
  logic       prep_ready;

  div_word_t  chain_word  [QuotW+1];
  logic       chain_valid [QuotW+1];
  logic       chain_ready [QuotW+1];

  rth_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_word  (prep_word)
  );

  rth_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_word   (prep_word),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_word  (chain_word[0])
  );

  for (genvar i = 0; i < QuotW; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  rth_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (chain_valid[QuotW]),
    .in_ready      (chain_ready[QuotW]),
    .in_word       (chain_word[QuotW]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hue           (hue),
    .hue_undefined (hue_undefined),
    .saturation    (saturation),
    .brightness    (brightness)
  );

endmodule
`default_nettype wire

@@ verif/rgb_to_hsv_pixel_test.sv @@
// Self-checking testbench for the RGB to HSV pixel converter.
`default_nettype none
module rgb_to_hsv_pixel_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rth_pkg::*;

  typedef struct packed {
    logic [14:0] hue;
    logic        undef;
    logic [12:0] sat;
    logic [7:0]  val;
  } hsv_t;

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic [7:0]  alpha = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] hue;
  logic        hue_undefined;
  logic [12:0] saturation;
  logic [7:0]  brightness;

  hsv_t expected_hsv[$];
  int   err_count = 0;
  int   quiet_cycles = 0;
  bit   idle_on = 1'b1;
  int   rx_hold = 0;

  rgb_to_hsv_pixel u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hue          (hue),
    .hue_undefined(hue_undefined),
    .saturation   (saturation),
    .brightness   (brightness)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hexcone conversion of one pixel; hue in 1/64 degree, saturation in Q1.12.
  function automatic hsv_t hsv_of(input logic [7:0] r, g, b, a);
    hsv_t    res;
    int      ri, gi, bi, mx, mn, delta, diff, num, h;
    sector_t sec;
    res = '0;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    if (ri == 0 && gi == 0 && bi == 0 && a == 8'd0) return res;
    if (ri == 255 && gi == 255 && bi == 255) begin
      res.val = 8'd255;
      return res;
    end
    mx = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    mn = ri;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    if (mx == 0) begin
      res.undef = 1'b1;
      return res;
    end
    delta = mx - mn;
    res.val = mx[7:0];
    res.sat = 13'((delta * 4096 + mx / 2) / mx);
    if (delta == 0) return res;
    // Ties go to red first, then green.
    if (ri == mx) begin
      sec = SEC_RED;
      diff = gi - bi;
    end else if (gi == mx) begin
      sec = SEC_GREEN;
      diff = bi - ri;
    end else begin
      sec = SEC_BLUE;
      diff = ri - gi;
    end
    num = int'(HueSector) * (2 * int'(sec) * delta + diff);
    if (num < 0) num += int'(HueFull) * delta;
    h = (2 * num + delta) / (2 * delta);
    if (h >= int'(HueFull)) h -= int'(HueFull);
    res.hue = h[14:0];
    return res;
  endfunction

  task automatic report(input string field, input int exp_v, input int got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    err_count++;
  endtask

  // Scoreboard and watchdog, both sampled at the rising edge.
  always @(posedge clk) begin
    hsv_t exp_w;
    if (!rst) begin
      if (in_valid && in_ready) expected_hsv.push_back(hsv_of(red, green, blue, alpha));
      if (out_valid && out_ready) begin
        if (expected_hsv.size() == 0) begin
          $display("%0t: unexpected word, expected none, got hue %0d", $time, hue);
          err_count++;
        end else begin
          exp_w = expected_hsv.pop_front();
          if (hue !== exp_w.hue) report("hue", int'(exp_w.hue), int'(hue));
          if (hue_undefined !== exp_w.undef) begin
            report("hue_undefined", int'(exp_w.undef), int'(hue_undefined));
          end
          if (saturation !== exp_w.sat) begin
            report("saturation", int'(exp_w.sat), int'(saturation));
          end
          if (brightness !== exp_w.val) begin
            report("brightness", int'(exp_w.val), int'(brightness));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
        $display("rgb_to_hsv_pixel test failed");
        $finish;
      end
    end
  end

  // Output side: random stalls per word while idle_on is set, plus a long hold when one is requested.
  initial begin
    int pause;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold > 0) begin
        pause = rx_hold;
        rx_hold = 0;
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end else begin
        pause = idle_on ? $urandom_range(0, 4) : 0;
        if (pause > 0) begin
          out_ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(input logic [7:0] r, g, b, a);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    alpha <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every outstanding word has come back.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_hsv.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    logic [7:0] r, g, b, a, m, lo;
    int         kind, pick;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    a = 8'($urandom);
    kind = $urandom_range(0, 15);
    case (kind)
      0: begin
        r = 8'd0;
        g = 8'd0;
        b = 8'd0;
        if ($urandom_range(0, 3) == 0) a = 8'd0;
      end
      1: begin
        g = r;
        b = r;
      end
      2: begin
        // Two channels share the maximum.
        m = 8'($urandom_range(1, 255));
        lo = 8'($urandom_range(0, int'(m)));
        pick = $urandom_range(0, 2);
        r = (pick == 0) ? lo : m;
        g = (pick == 1) ? lo : m;
        b = (pick == 2) ? lo : m;
      end
      3: begin
        r = 8'd255;
        g = 8'd255;
        b = 8'd255;
      end
      4: begin
        r = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
        g = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
        b = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
      end
      default: ;
    endcase
    send_pixel(r, g, b, a);
  endtask

  task automatic test_special_pixels();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);       // all-zero word
    send_pixel(8'd0, 8'd0, 8'd0, 8'd1);       // black, alpha set
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0); // white
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd7); // grey
    send_pixel(8'd1, 8'd1, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd0);   // red wins the tie
    send_pixel(8'd255, 8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd0);   // green wins the tie
    send_pixel(8'd255, 8'd0, 8'd1, 8'd0);     // negative hue wraps up
    send_pixel(8'd255, 8'd254, 8'd255, 8'd0); // hue of exactly 300 degrees
    send_pixel(8'd255, 8'd255, 8'd254, 8'd170);
    send_pixel(8'd254, 8'd255, 8'd255, 8'd85);
    send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd2, 8'd1, 8'd0, 8'd0);       // full saturation, hue 30 degrees
    send_pixel(8'd10, 8'd3, 8'd7, 8'd0);
    send_pixel(8'd100, 8'd200, 8'd50, 8'd255);
    send_pixel(8'd17, 8'd90, 8'd201, 8'd128);
    drain_pipe();
  endtask

  task automatic test_random_pixels(input int count);
    repeat (count) send_random_pixel();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (300) send_random_pixel();
    drain_pipe();
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    rx_hold = 300;
    repeat (100) send_random_pixel();
    drain_pipe();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_pixels();
    test_random_pixels(750);
    drain_pipe();
    test_full_rate();
    test_output_hold();
    test_random_pixels(750);
    drain_pipe();
    if (err_count == 0 && expected_hsv.size() == 0) begin
      $display("rgb_to_hsv_pixel test passed");
    end else begin
      $display("rgb_to_hsv_pixel test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
